// ===== design/u1lmu_pkg.sv =====
package u1lmu_pkg;

    // Lattice extent.
    localparam int SIZE_X = 8;
    localparam int SIZE_Y = 8;
    localparam int SIZE_T = 8;
    localparam int LINK_COUNT = 3 * SIZE_X * SIZE_Y * SIZE_T;
    localparam int ADDR_W = $clog2(LINK_COUNT);
    localparam int XW = $clog2(SIZE_X);
    localparam int YW = $clog2(SIZE_Y);
    localparam int TW = $clog2(SIZE_T);

    // Fixed field widths.
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 11;
    localparam int PHASE_W = 16;
    localparam int BETA_W  = 16;

    localparam logic [BETA_W-1:0] BETA_RESET = 16'd256;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // Quarter-wave cosine in Q1.14, 512 phase units apart.
    localparam logic [14:0] COS_TAB [33] = '{
        15'd16384, 15'd16364, 15'd16305, 15'd16207, 15'd16069, 15'd15893, 15'd15679,
        15'd15426, 15'd15137, 15'd14811, 15'd14449, 15'd14053, 15'd13623, 15'd13160,
        15'd12665, 15'd12140, 15'd11585, 15'd11003, 15'd10394, 15'd9760, 15'd9102,
        15'd8423, 15'd7723, 15'd7005, 15'd6270, 15'd5520, 15'd4756, 15'd3981,
        15'd3196, 15'd2404, 15'd1606, 15'd804, 15'd0
    };

    // Factors round(65536*exp(-2^i/256)) for each bit of the exponent.
    localparam logic [15:0] EXP_BIT [12] = '{
        16'd65280, 16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
        16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200, 16'd22
    };

    // Cosine of a phase in Q1.14 with linear interpolation.
    function automatic logic signed [15:0] cos_q14(input logic [PHASE_W-1:0] p);
        logic [14:0] u;
        logic [5:0]  k;
        logic [8:0]  frac;
        int          a;
        int          b;
        int          v;
        u    = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
        k    = u[14:9];
        frac = u[8:0];
        if (k >= 6'd32) begin
            v = 0;
        end else begin
            a = int'(COS_TAB[k]);
            b = int'(COS_TAB[k + 6'd1]);
            v = a - (((a - b) * int'(frac) + 256) >>> 9);
        end
        if (p[15] != p[14]) begin
            v = -v;
        end
        return 16'(v);
    endfunction

    // Store address of a link.
    function automatic logic [ADDR_W-1:0] site_addr(input logic [XW-1:0] x,
                                                    input logic [YW-1:0] y,
                                                    input logic [TW-1:0] t,
                                                    input logic [1:0]    d);
        int a;
        a = 3 * (int'(x) + SIZE_X * (int'(y) + SIZE_Y * int'(t))) + int'(d);
        return ADDR_W'(a);
    endfunction

endpackage

// ===== design/u1_lattice_metropolis_link_update.sv =====
// Metropolis updater for a compact U(1) gauge field on a periodic 3D lattice.
// Link phases live in one single-port-read synchronous memory. A load writes a
// link whose index is in range and a read waits for the registered memory data,
// each before its result goes to the output register; an update reads its 13
// links one per cycle from the memory, evaluates 8 cosines one per cycle through
// a shared table, forms the exponent and runs the acceptance threshold
// through 12 iterations of one multiplier. Only one item is worked on at a
// time; a finished result waits in the output register while the next item
// is taken. The coupling register may be written at any time the block is idle.
module u1_lattice_metropolis_link_update (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [u1lmu_pkg::MODE_W-1:0]    i_mode,
    input  logic [u1lmu_pkg::INDEX_W-1:0]   i_link_index,
    input  logic [u1lmu_pkg::PHASE_W-1:0]   i_link_phase_in,
    input  logic signed [15:0]              i_proposal_step,
    input  logic [15:0]                     i_uniform_draw,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [u1lmu_pkg::INDEX_W-1:0]   o_link_address,
    output logic [u1lmu_pkg::PHASE_W-1:0]   o_link_phase_out,
    output logic                            o_accepted,
    output logic                            o_sweep_done,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [u1lmu_pkg::BETA_W-1:0]    i_cfg_data
);
    import u1lmu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RDWAIT, S_RDGET, S_READ, S_COS, S_EXP, S_THR, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    logic [PHASE_W-1:0] mem [LINK_COUNT];
    logic [PHASE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PHASE_W-1:0] wr_data;

    logic [BETA_W-1:0]  r_beta;
    logic [INDEX_W-1:0] r_idx;
    logic [PHASE_W-1:0] r_phase_in;
    logic [15:0]        r_prop;
    logic [15:0]        r_draw;

    logic [1:0]    r_mu;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [TW-1:0] r_t;
    logic          last_link;

    logic [3:0]         r_step;
    logic [3:0]         r_dstep;
    logic               r_dv;
    logic [PHASE_W-1:0] r_old;
    logic [PHASE_W-1:0] r_new;
    logic [PHASE_W-1:0] r_stp [4];
    logic [2:0]         r_k;
    logic signed [18:0] r_d;
    logic [12:0]        r_yq;
    logic [3:0]         r_i;
    logic [16:0]        r_acc;

    logic [INDEX_W-1:0] r_p_addr;
    logic [PHASE_W-1:0] r_p_phase;
    logic               r_p_acc;
    logic               r_p_done;

    logic               idx_ok;
    logic               out_free;

    // Neighbor address decode for the current read step.
    logic          s_j;
    logic [2:0]    s_r;
    logic [1:0]    s_nu;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [TW-1:0] ct;
    logic [1:0]    cdir;
    logic          plus_mu;
    logic          plus_nu;
    logic          minus_nu;
    logic [ADDR_W-1:0] upd_addr;
    logic [ADDR_W-1:0] own_addr;

    // Decode of the step whose read data is present.
    logic       d_j;
    logic [2:0] d_r;
    logic [1:0] d_slot;

    logic signed [15:0] cos_val;
    logic [PHASE_W-1:0] cos_arg;
    logic [17:0]        neg_d;
    logic [33:0]        y_prod;
    logic [19:0]        y_q;
    logic [32:0]        acc_prod;
    logic [16:0]        thr;
    logic               ok;
    logic [PHASE_W-1:0] fwd_unused_guard;

    assign idx_ok   = 32'(r_idx) < LINK_COUNT;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign fwd_unused_guard = '0;

    assign last_link = (r_mu == 2'd2) && (32'(r_x) == SIZE_X - 1) &&
                       (32'(r_y) == SIZE_Y - 1) && (32'(r_t) == SIZE_T - 1);
    assign own_addr  = site_addr(r_x, r_y, r_t, r_mu);

    // Step decode: step 0 is the link itself, then six links per other direction.
    always_comb begin
        s_j  = (r_step >= 4'd7);
        s_r  = s_j ? 3'(r_step - 4'd7) : 3'(r_step - 4'd1);
        d_j  = (r_dstep >= 4'd7);
        d_r  = d_j ? 3'(r_dstep - 4'd7) : 3'(r_dstep - 4'd1);
        d_slot = {d_j, (d_r >= 3'd3)};
        case (r_mu)
            2'd0:    s_nu = s_j ? 2'd2 : 2'd1;
            2'd1:    s_nu = s_j ? 2'd2 : 2'd0;
            default: s_nu = s_j ? 2'd1 : 2'd0;
        endcase
    end

    // Coordinates of the link read at this step.
    always_comb begin
        cx = r_x;
        cy = r_y;
        ct = r_t;
        plus_mu  = (r_step != 4'd0) && ((s_r == 3'd0) || (s_r == 3'd5));
        plus_nu  = (r_step != 4'd0) && (s_r == 3'd1);
        minus_nu = (r_step != 4'd0) && ((s_r == 3'd3) || (s_r == 3'd4) || (s_r == 3'd5));
        if (r_step == 4'd0 || s_r == 3'd1 || s_r == 3'd4) begin
            cdir = r_mu;
        end else begin
            cdir = s_nu;
        end
        if (plus_mu) begin
            case (r_mu)
                2'd0:    cx = (32'(cx) == SIZE_X - 1) ? '0 : cx + XW'(1);
                2'd1:    cy = (32'(cy) == SIZE_Y - 1) ? '0 : cy + YW'(1);
                default: ct = (32'(ct) == SIZE_T - 1) ? '0 : ct + TW'(1);
            endcase
        end
        if (plus_nu) begin
            case (s_nu)
                2'd0:    cx = (32'(cx) == SIZE_X - 1) ? '0 : cx + XW'(1);
                2'd1:    cy = (32'(cy) == SIZE_Y - 1) ? '0 : cy + YW'(1);
                default: ct = (32'(ct) == SIZE_T - 1) ? '0 : ct + TW'(1);
            endcase
        end
        if (minus_nu) begin
            case (s_nu)
                2'd0:    cx = (cx == '0) ? XW'(SIZE_X - 1) : cx - XW'(1);
                2'd1:    cy = (cy == '0) ? YW'(SIZE_Y - 1) : cy - YW'(1);
                default: ct = (ct == '0) ? TW'(SIZE_T - 1) : ct - TW'(1);
            endcase
        end
        upd_addr = site_addr(cx, cy, ct, cdir);
    end

    // Memory port selection.
    always_comb begin
        rd_addr = (r_state == S_READ) ? upd_addr : ADDR_W'(r_idx);
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(r_idx);
        wr_data = r_phase_in;
        if (r_state == S_LOAD && idx_ok) begin
            wr_en = 1'b1;
        end
        if (r_state == S_FIN && ok) begin
            wr_en   = 1'b1;
            wr_addr = own_addr;
            wr_data = r_new;
        end
    end

    // Cosine, exponent and threshold arithmetic.
    always_comb begin
        cos_arg  = (r_k[0] ? r_new : r_old) + r_stp[r_k[2:1]] + fwd_unused_guard;
        cos_val  = cos_q14(cos_arg);
        neg_d    = 18'(-r_d);
        y_prod   = 34'(r_beta) * 34'(neg_d);
        y_q      = 20'((y_prod + 34'd8192) >> 14);
        acc_prod = 33'(r_acc) * 33'(EXP_BIT[r_i]);
        thr      = r_yq[12] ? 17'd0 : r_acc;
        ok       = 17'(r_draw) < thr;
    end

    // Link store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Coupling register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= BETA_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_beta <= i_cfg_data;
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mu    <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_t     <= '0;
            r_dv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx      <= i_link_index;
                        r_phase_in <= i_link_phase_in;
                        r_prop     <= i_proposal_step;
                        r_draw     <= i_uniform_draw;
                        r_step     <= '0;
                        r_dv       <= 1'b0;
                        case (i_mode)
                            MODE_LOAD:   r_state <= S_LOAD;
                            MODE_UPDATE: r_state <= S_READ;
                            MODE_READ:   r_state <= S_RDWAIT;
                            default: begin
                                r_p_addr  <= i_link_index;
                                r_p_phase <= '0;
                                r_p_acc   <= 1'b0;
                                r_p_done  <= 1'b0;
                                r_state   <= S_OUT;
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_p_addr  <= r_idx;
                    r_p_phase <= idx_ok ? r_phase_in : '0;
                    r_p_acc   <= 1'b0;
                    r_p_done  <= 1'b0;
                    r_state   <= S_OUT;
                end
                S_RDWAIT: begin
                    r_state <= S_RDGET;
                end
                S_RDGET: begin
                    r_p_addr  <= r_idx;
                    r_p_phase <= idx_ok ? r_rd_data : '0;
                    r_p_acc   <= 1'b0;
                    r_p_done  <= 1'b0;
                    r_state   <= S_OUT;
                end
                S_READ: begin
                    // Issue one read per cycle and fold in the data of the last one.
                    r_dstep <= r_step;
                    r_dv    <= (r_step <= 4'd12);
                    if (r_step <= 4'd12) begin
                        r_step <= r_step + 4'd1;
                    end
                    if (r_dv) begin
                        if (r_dstep == 4'd0) begin
                            r_old <= r_rd_data;
                            r_new <= r_rd_data + r_prop;
                        end else if (d_r == 3'd0 || d_r == 3'd3) begin
                            r_stp[d_slot] <= r_rd_data;
                        end else begin
                            r_stp[d_slot] <= r_stp[d_slot] - r_rd_data;
                        end
                    end
                    if (r_step == 4'd13) begin
                        r_dv    <= 1'b0;
                        r_k     <= '0;
                        r_d     <= '0;
                        r_state <= S_COS;
                    end
                end
                S_COS: begin
                    // Old cosines subtract, new cosines add.
                    if (r_k[0]) begin
                        r_d <= r_d + 19'(cos_val);
                    end else begin
                        r_d <= r_d - 19'(cos_val);
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_d < 0) begin
                        r_yq <= (y_q > 20'd4096) ? 13'd4096 : 13'(y_q);
                    end else begin
                        r_yq <= '0;
                    end
                    r_acc   <= 17'd65536;
                    r_i     <= '0;
                    r_state <= S_THR;
                end
                S_THR: begin
                    if (r_yq[r_i]) begin
                        r_acc <= 17'((acc_prod + 33'd32768) >> 16);
                    end
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd11) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_p_addr  <= INDEX_W'(own_addr);
                    r_p_phase <= ok ? r_new : r_old;
                    r_p_acc   <= ok;
                    r_p_done  <= last_link;
                    // Advance the sweep: direction, then t, then y, then x.
                    if (r_mu != 2'd2) begin
                        r_mu <= r_mu + 2'd1;
                    end else begin
                        r_mu <= '0;
                        if (32'(r_t) != SIZE_T - 1) begin
                            r_t <= r_t + TW'(1);
                        end else begin
                            r_t <= '0;
                            if (32'(r_y) != SIZE_Y - 1) begin
                                r_y <= r_y + YW'(1);
                            end else begin
                                r_y <= '0;
                                r_x <= (32'(r_x) == SIZE_X - 1) ? '0 : r_x + XW'(1);
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid          <= 1'b1;
                        o_link_address   <= r_p_addr;
                        o_link_phase_out <= r_p_phase;
                        o_accepted       <= r_p_acc;
                        o_sweep_done     <= r_p_done;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The read step counter never runs past the end of the staple walk.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_step <= 4'd13)
        else $error("read step out of range");

    // A transfer in always starts work on the item.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state != S_IDLE)
        else $error("accepted item not started");

    // Sweep coordinates stay on the lattice.
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mu <= 2'd2 && 32'(r_x) < SIZE_X && 32'(r_y) < SIZE_Y && 32'(r_t) < SIZE_T)
        else $error("sweep position off lattice");

endmodule
